FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define BDR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bdr assertion failed");

// next-cycle implication
`define BDR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bdr assertion failed");

`endif

FILE: rtl/bdr_pkg.sv
// shared types and constants of the bounded deque
package bdr_pkg;

    localparam int DATA_W    = 32;
    localparam int OPC_W     = 3;
    localparam int STAT_W    = 2;
    localparam int DEPTH_DEF = 32;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_DISPLAY    = 3'd4
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PREV,
        CMD_NEXT,
        CMD_VALUE,
        CMD_HEAD
    } t_cell_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SHOW = 2'b10
    } t_state;

endpackage

FILE: rtl/bdr_in_if.sv
// request channel: opcode and value with valid/ready
interface bdr_in_if;
    import bdr_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

FILE: rtl/bdr_out_if.sv
// result channel: data, status and last with valid/ready
interface bdr_out_if;
    import bdr_pkg::*;

    logic              valid;
    logic              ready;
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0] status;
    logic              last;

    modport source (output valid, output data, output status, output last, input ready);
    modport sink   (input valid, input data, input status, input last, output ready);
endinterface

FILE: rtl/bounded_deque_ring.sv
// bounded double-ended queue of signed 32-bit values in a chain of cells
//
// request channel i_in carries opcode and value; result channel o_out carries
// data, status and last. cell 0 always holds the front entry, cell count-1 the
// rear. push front shifts the chain towards the rear, pop front shifts it
// towards the front, push rear writes the cell at the fill count and pop rear
// reads the cell just below it.
// push and pop: once accepted, their single result appears in the output
// register on the next cycle; one item per cycle while o_out is taken.
// display: while o_out is taken the chain rotates one cell per cycle so cell 0
// streams every entry from front to rear, one transfer per cycle, and i_in is
// held not ready until the rotation completes.
// a display or pop on an empty queue gives one result with status empty,
// a push on a full queue gives status full; opcodes five to seven are dropped.
// reset empties the queue at once; cell contents are not cleared.
// when the receiver stalls the result is held and i_in drops ready
module bounded_deque_ring #(
    parameter int DEPTH = bdr_pkg::DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bdr_in_if.sink   i_in,
    bdr_out_if.source o_out
);
    import bdr_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    t_cell_cmd         w_cmd [DEPTH];
    logic [DATA_W-1:0] w_cell [DEPTH];
    logic [DATA_W-1:0] w_rear;
    logic              w_out_free;
    logic              w_in_ready;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic              w_idx_last;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_idx_last = ((CW'(r_idx) + CW'(1)) == r_count);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] w_prev;
        logic [DATA_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = i_in.value;
        end else begin : g_mid
            assign w_prev = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign w_next = w_cell[0];
        end else begin : g_body
            assign w_next = w_cell[g+1];
        end

        bdr_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd[g]),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_value (i_in.value),
            .i_head  (w_cell[0]),
            .o_data  (w_cell[g])
        );
    end

    always_comb begin
        w_rear = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (r_count == CW'(k + 1)) begin
                w_rear = w_cell[k];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        for (int k = 0; k < DEPTH; k++) begin
            w_cmd[k] = CMD_HOLD;
        end

        if (w_out_free) begin
            n_out_valid  = 1'b0;
            n_out_data   = '0;
            n_out_status = STAT_OK;
            n_out_last   = 1'b1;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        unique case (t_opcode'(i_in.opcode))
                            OP_PUSH_FRONT: begin
                                n_out_valid = 1'b1;
                                if (w_full) begin
                                    n_out_status = STAT_FULL;
                                end else begin
                                    n_count = r_count + CW'(1);
                                    for (int k = 0; k < DEPTH; k++) begin
                                        w_cmd[k] = CMD_PREV;
                                    end
                                end
                            end
                            OP_PUSH_REAR: begin
                                n_out_valid = 1'b1;
                                if (w_full) begin
                                    n_out_status = STAT_FULL;
                                end else begin
                                    n_count = r_count + CW'(1);
                                    for (int k = 0; k < DEPTH; k++) begin
                                        if (CW'(k) == r_count) begin
                                            w_cmd[k] = CMD_VALUE;
                                        end
                                    end
                                end
                            end
                            OP_POP_FRONT: begin
                                n_out_valid = 1'b1;
                                if (w_empty) begin
                                    n_out_status = STAT_EMPTY;
                                end else begin
                                    n_out_data = w_cell[0];
                                    n_count    = r_count - CW'(1);
                                    for (int k = 0; k < DEPTH; k++) begin
                                        w_cmd[k] = CMD_NEXT;
                                    end
                                end
                            end
                            OP_POP_REAR: begin
                                n_out_valid = 1'b1;
                                if (w_empty) begin
                                    n_out_status = STAT_EMPTY;
                                end else begin
                                    n_out_data = w_rear;
                                    n_count    = r_count - CW'(1);
                                end
                            end
                            OP_DISPLAY: begin
                                if (w_empty) begin
                                    n_out_valid  = 1'b1;
                                    n_out_status = STAT_EMPTY;
                                end else begin
                                    n_state = ST_SHOW;
                                    n_idx   = '0;
                                end
                            end
                            default: begin
                                n_out_valid = 1'b0;
                            end
                        endcase
                    end
                end
                ST_SHOW: begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_cell[0];
                    n_out_last  = w_idx_last;
                    for (int k = 0; k < DEPTH; k++) begin
                        if (CW'(k) == r_count - CW'(1)) begin
                            w_cmd[k] = CMD_HEAD;
                        end else begin
                            w_cmd[k] = CMD_NEXT;
                        end
                    end
                    if (w_idx_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign i_in.ready   = w_in_ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out_data;
    assign o_out.status = r_out_status;
    assign o_out.last   = r_out_last;
endmodule

FILE: rtl/bdr_cell.sv
// one storage cell of the deque chain
module bdr_cell (
    input  logic                        i_clk,
    input  bdr_pkg::t_cell_cmd          i_cmd,
    input  logic [bdr_pkg::DATA_W-1:0]  i_prev,
    input  logic [bdr_pkg::DATA_W-1:0]  i_next,
    input  logic [bdr_pkg::DATA_W-1:0]  i_value,
    input  logic [bdr_pkg::DATA_W-1:0]  i_head,
    output logic [bdr_pkg::DATA_W-1:0]  o_data
);
    import bdr_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        unique case (i_cmd)
            CMD_PREV:  n_data = i_prev;
            CMD_NEXT:  n_data = i_next;
            CMD_VALUE: n_data = i_value;
            CMD_HEAD:  n_data = i_head;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

FILE: rtl/bdr_checker.sv
// port-level checks of the bounded deque, bound to the top level
`include "assert_macros.svh"

module bdr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [bdr_pkg::DATA_W-1:0] i_out_data,
    input logic [bdr_pkg::STAT_W-1:0] i_out_status,
    input logic                       i_out_last
);
    import bdr_pkg::*;

    // a stalled result holds until its transfer
    `BDR_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data) && $stable(i_out_status) && $stable(i_out_last))

    // no new request is taken while a result is stuck
    `BDR_ASSERT_IMP(a_stall_blocks_in, i_out_valid && !i_out_ready, !i_in_ready)

    // empty and full reports always close their item
    `BDR_ASSERT_IMP(a_err_last, i_out_valid && (i_out_status != STAT_OK), i_out_last && (i_out_data == '0))

    // no reserved status code
    `BDR_ASSERT_IMP(a_status_code, i_out_valid, (i_out_status == STAT_OK) || (i_out_status == STAT_EMPTY) || (i_out_status == STAT_FULL))
endmodule

bind bounded_deque_ring bdr_checker u_bdr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_data   (o_out.data),
    .i_out_status (o_out.status),
    .i_out_last   (o_out.last)
);
